>>> hdl/assert_macros.svh
// Assertion helpers for the modules that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hdl/rau_pkg.sv
package rau_pkg;

    localparam int FIELD_W = 16;
    localparam int DEN_IN_W = FIELD_W - 1;
    localparam int NUM_W = 2 * FIELD_W;
    localparam int DEN_W = 2 * FIELD_W - 2;
    localparam int PROD_W = 2 * FIELD_W + 1;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

endpackage

>>> hdl/rau_divider.sv
module rau_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::NUM_W-1:0]  i_dividend,
    input  logic [rau_pkg::NUM_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rau_pkg::NUM_W-1:0]  o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [rau_pkg::CNT_W-1:0]  r_cnt;
    logic [rau_pkg::NUM_W-1:0]  r_rem;
    logic [rau_pkg::NUM_W-1:0]  r_quo;
    logic [rau_pkg::NUM_W-1:0]  r_dvs;
    logic [rau_pkg::NUM_W:0]    shifted;
    logic [rau_pkg::NUM_W:0]    diff;
    logic                       fits;

    // One quotient bit per cycle, most significant first.
    assign shifted = {r_rem, r_quo[rau_pkg::NUM_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rau_pkg::CNT_W'(rau_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[rau_pkg::NUM_W-1:0] : shifted[rau_pkg::NUM_W-1:0];
            r_quo <= {r_quo[rau_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/rau_gcd.sv
module rau_gcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rau_pkg::NUM_W-1:0]  i_x,
    input  logic [rau_pkg::NUM_W-1:0]  i_y,
    output logic                       o_done,
    output logic [rau_pkg::NUM_W-1:0]  o_gcd
);

    logic                       r_busy;
    logic                       r_done;
    logic [rau_pkg::NUM_W-1:0]  r_x;
    logic [rau_pkg::NUM_W-1:0]  r_y;
    logic [rau_pkg::CNT_W-1:0]  r_k;
    logic [rau_pkg::NUM_W:0]    diff;
    logic [rau_pkg::NUM_W:0]    ndiff;

    // Both operands are non-zero on start, so the odd/odd subtraction never
    // reaches zero and the loop ends when the two values meet.
    assign diff  = {1'b0, r_x} - {1'b0, r_y};
    assign ndiff = -diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_x[0] && r_y[0] && !diff[rau_pkg::NUM_W]
                         && (diff[rau_pkg::NUM_W-1:0] == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_k <= '0;
        end else if (r_busy) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (diff[rau_pkg::NUM_W]) begin
                r_y <= ndiff[rau_pkg::NUM_W:1];
            end else if (diff[rau_pkg::NUM_W-1:0] != '0) begin
                r_x <= diff[rau_pkg::NUM_W:1];
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_x << r_k;

endmodule

>>> hdl/rational_arithmetic_unit_top.sv
// Channel   Ports                                      Handshake
// command   i_command, i_a_num, i_a_den, i_b_num,      start high while busy low
//           i_b_den
// result    o_res_num, o_res_den, o_equal, o_div_zero  o_valid, one cycle, no stall
//
// Compare and unused commands show their result in the cycle after acceptance.
// Arithmetic runs two or three products on one shared multiplier, a binary GCD of one
// shift or subtract a cycle, and two divisions on a shared divider: the numerator and
// then the denominator are divided by the GCD before the result is shown.
// A zero or undefined arithmetic result is shown from the prepare step, skipping the GCD and divisions.
// For arithmetic, busy is high from the cycle after acceptance until the result is shown.
// Reset is synchronous and returns the sequencer to idle; results cannot stall.
`include "assert_macros.svh"

module rational_arithmetic_unit_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_command,
    input  logic signed [rau_pkg::FIELD_W-1:0] i_a_num,
    input  logic [rau_pkg::DEN_IN_W-1:0]     i_a_den,
    input  logic signed [rau_pkg::FIELD_W-1:0] i_b_num,
    input  logic [rau_pkg::DEN_IN_W-1:0]     i_b_den,
    output logic                             o_valid,
    output logic signed [rau_pkg::NUM_W-1:0] o_res_num,
    output logic [rau_pkg::DEN_W-1:0]        o_res_den,
    output logic                             o_equal,
    output logic                             o_div_zero
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_PREP = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;

    localparam int OP_W = rau_pkg::FIELD_W + 1;

    logic [3:0]                         r_state;
    logic [3:0]                         n_state;
    logic [2:0]                         r_cmd;
    logic [rau_pkg::FIELD_W-1:0]        r_an;
    logic [rau_pkg::DEN_IN_W-1:0]       r_ad;
    logic [rau_pkg::FIELD_W-1:0]        r_bn;
    logic [rau_pkg::DEN_IN_W-1:0]       r_bd;
    logic signed [rau_pkg::PROD_W-1:0]  r_num;
    logic signed [rau_pkg::PROD_W-1:0]  r_tmp;
    logic signed [rau_pkg::PROD_W-1:0]  r_den;
    logic                               r_neg;
    logic [rau_pkg::NUM_W-1:0]          r_mn;
    logic [rau_pkg::DEN_W-1:0]          r_md;
    logic [rau_pkg::NUM_W-1:0]          r_qn;
    logic                               r_valid;
    logic [rau_pkg::NUM_W-1:0]          r_res_num;
    logic [rau_pkg::DEN_W-1:0]          r_res_den;
    logic                               r_equal;
    logic                               r_div_zero;

    logic                               accept;
    logic signed [OP_W-1:0]             an_ext, bn_ext, ad_ext, bd_ext;
    logic signed [OP_W-1:0]             mul_a, mul_b;
    logic signed [2*OP_W-1:0]           prod;
    logic [rau_pkg::PROD_W-1:0]         abs_num;
    logic [rau_pkg::PROD_W-1:0]         abs_den;
    logic                               gcd_start, gcd_done;
    logic [rau_pkg::NUM_W-1:0]          gcd_g;
    logic                               div_start, div_done;
    logic [rau_pkg::NUM_W-1:0]          div_dividend, div_quo;
    logic                               zero_case;

    assign accept = start && (r_state == S_IDLE);

    assign an_ext = {r_an[rau_pkg::FIELD_W-1], r_an};
    assign bn_ext = {r_bn[rau_pkg::FIELD_W-1], r_bn};
    assign ad_ext = {2'b00, r_ad};
    assign bd_ext = {2'b00, r_bd};

    // The single multiplier is steered through the two or three products of the command.
    always_comb begin
        mul_a = an_ext;
        mul_b = bd_ext;
        unique case (r_state)
            S_MUL1: begin
                mul_a = an_ext;
                mul_b = (r_cmd == rau_pkg::CMD_MUL) ? bn_ext : bd_ext;
            end
            S_MUL2: begin
                mul_a = bn_ext;
                mul_b = ad_ext;
            end
            S_MUL3: begin
                mul_a = ad_ext;
                mul_b = (r_cmd == rau_pkg::CMD_DIV) ? bn_ext : bd_ext;
            end
            default: begin
                mul_a = an_ext;
                mul_b = bd_ext;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign abs_num   = r_num[rau_pkg::PROD_W-1] ? -r_num : r_num;
    assign abs_den   = r_den[rau_pkg::PROD_W-1] ? -r_den : r_den;
    assign zero_case = (r_den == '0) || (r_num == '0);

    assign gcd_start    = (r_state == S_PREP) && !zero_case;
    assign div_start    = ((r_state == S_GCD) && gcd_done) || ((r_state == S_DIVN) && div_done);
    assign div_dividend = (r_state == S_GCD) ? r_mn
                                             : {{(rau_pkg::NUM_W - rau_pkg::DEN_W){1'b0}}, r_md};

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (abs_num[rau_pkg::NUM_W-1:0]),
        .i_y     ({{(rau_pkg::NUM_W - rau_pkg::DEN_W){1'b0}}, abs_den[rau_pkg::DEN_W-1:0]}),
        .o_done  (gcd_done),
        .o_gcd   (gcd_g)
    );

    rau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (gcd_g),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_command <= rau_pkg::CMD_DIV)) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state = ((r_cmd == rau_pkg::CMD_ADD) || (r_cmd == rau_pkg::CMD_SUB))
                          ? S_MUL2 : S_MUL3;
            end
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_PREP;
            S_PREP: n_state = zero_case ? S_IDLE : S_GCD;
            S_GCD:  if (gcd_done) n_state = S_DIVN;
            S_DIVN: if (div_done) n_state = S_DIVD;
            S_DIVD: if (div_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (accept && (i_command > rau_pkg::CMD_DIV))
                    || ((r_state == S_PREP) && zero_case)
                    || ((r_state == S_DIVD) && div_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_command;
            r_an       <= i_a_num;
            r_ad       <= i_a_den;
            r_bn       <= i_b_num;
            r_bd       <= i_b_den;
            r_res_num  <= '0;
            r_res_den  <= rau_pkg::DEN_W'(1);
            r_equal    <= (i_command == rau_pkg::CMD_CMP) && (i_a_num == i_b_num)
                          && (i_a_den == i_b_den);
            r_div_zero <= 1'b0;
        end
        unique case (r_state)
            S_MUL1: r_num <= prod[rau_pkg::PROD_W-1:0];
            S_MUL2: r_tmp <= prod[rau_pkg::PROD_W-1:0];
            S_MUL3: begin
                r_den <= prod[rau_pkg::PROD_W-1:0];
                if (r_cmd == rau_pkg::CMD_ADD) begin
                    r_num <= r_num + r_tmp;
                end else if (r_cmd == rau_pkg::CMD_SUB) begin
                    r_num <= r_num - r_tmp;
                end
            end
            S_PREP: begin
                r_neg      <= r_num[rau_pkg::PROD_W-1] ^ r_den[rau_pkg::PROD_W-1];
                r_mn       <= abs_num[rau_pkg::NUM_W-1:0];
                r_md       <= abs_den[rau_pkg::DEN_W-1:0];
                r_equal    <= 1'b0;
                r_div_zero <= (r_den == '0);
            end
            S_DIVN: if (div_done) r_qn <= div_quo;
            S_DIVD: begin
                if (div_done) begin
                    r_res_num <= r_neg ? -r_qn : r_qn;
                    r_res_den <= div_quo[rau_pkg::DEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_equal    = r_equal;
    assign o_div_zero = r_div_zero;

    `ASSERT_PROP(a_accept_busy, i_clk, i_rst_n, (accept && (i_command <= rau_pkg::CMD_DIV)) |=> busy, "arithmetic item accepted without going busy")
    `ASSERT_PROP(a_valid_idle, i_clk, i_rst_n, o_valid |-> !busy, "result shown while still busy")
    `ASSERT_PROP(a_den_nonzero, i_clk, i_rst_n, o_valid |-> (o_res_den != '0), "result denominator is zero")
    `ASSERT_PROP(a_dz_result, i_clk, i_rst_n, (o_valid && o_div_zero) |-> ((o_res_num == '0) && (o_res_den == rau_pkg::DEN_W'(1))), "divide-by-zero result is not 0/1")
    `ASSERT_NEVER(a_gcd_stray, i_clk, i_rst_n, gcd_done && (r_state != S_GCD), "GCD finished outside its step")

endmodule
